/* rtl/size_class_free_list_allocator_top_defines.svh */
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Implication checked in the same cycle, quiet during reset
`define SCFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, quiet during reset
`define SCFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/scfl_pkg.sv */
package scfl_pkg;

  localparam logic [16:0] MAX_REQUEST    = 17'h10000;
  localparam logic [4:0]  SPLIT_MIN_BITS = 5'd8;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  localparam logic [16:0] HEAP_BYTES_RESET = 17'h10000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_SIZE  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    logic        op;
    logic [16:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [16:0] granted_size;
    logic [31:0] in_use_total;
    logic [1:0]  status;
  } rsp_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic        op;
    logic        bad_size;
    logic [4:0]  cls_main;
    logic [4:0]  cls_rem;
    logic [16:0] granted;
    logic [31:0] offset;
  } entry_t;

  // Bit width of a 17-bit value (position of the top set bit plus one)
  function automatic logic [4:0] width_of(input logic [16:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

/* rtl/scfl_front.sv */
module scfl_front #(
  parameter int ALIGN_BYTES = 4
) (
  input  logic           start,
  input  logic           busy,
  input  scfl_pkg::req_t request,
  input  logic [31:0]    heap_base,
  output logic           push,
  output scfl_pkg::entry_t entry
);
  import scfl_pkg::*;

  localparam logic [17:0] ALIGN_MASK = 18'(ALIGN_BYTES - 1);

  // Round up to the alignment, then up to a power of two
  function automatic logic [16:0] round_pow2(input logic [16:0] s);
    logic [17:0] r;
    logic [17:0] rm1;
    r   = ({1'b0, s} + ALIGN_MASK) & ~ALIGN_MASK;
    rm1 = r - 18'd1;
    return 17'(18'd1 << width_of(rm1[16:0]));
  endfunction

  logic [16:0] s;
  logic        bad;
  logic [4:0]  bits;
  logic [16:0] p;
  logic [16:0] main_part;
  logic [16:0] rem_part;
  logic        split;

  // Classify the request into its (main, remainder) class
  always_comb begin
    s         = request.request_size;
    bad       = (s == 17'd0) || (s > MAX_REQUEST);
    bits      = width_of(s - 17'd1);
    p         = round_pow2(s);
    main_part = 17'd1 << (bits - 5'd1);
    rem_part  = round_pow2(s - main_part);
    split     = (p > s) && (bits > SPLIT_MIN_BITS) && (main_part != rem_part);

    entry.op       = request.op;
    entry.bad_size = bad;
    entry.cls_main = split ? (bits - 5'd1) : bits;
    entry.cls_rem  = split ? width_of(rem_part - 17'd1) : 5'd0;
    entry.granted  = bad ? 17'd0 : (split ? (main_part + rem_part) : p);
    entry.offset   = request.free_address - heap_base;
  end

  assign push = start & ~busy;

endmodule

/* rtl/scfl_queue.sv */
module scfl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scfl_pkg::entry_t wr_entry,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output scfl_pkg::entry_t rd_entry
);
  import scfl_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Hold queued transactions
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign rd_entry = slots[rd_ptr];

endmodule

/* rtl/scfl_back.sv */
module scfl_back #(
  parameter int CLASS_COUNT = 32,
  parameter int HEAP_WORDS  = 16384,
  parameter int ALIGN_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  scfl_pkg::entry_t q_entry,
  output logic             pop,
  input  logic [31:0]      heap_base,
  input  logic [16:0]      heap_bytes,
  output logic             clearing,
  output logic             done,
  output scfl_pkg::rsp_t   result
);
  import scfl_pkg::*;

  localparam int HEADS    = CLASS_COUNT * CLASS_COUNT;
  localparam int HA_W     = $clog2(HEADS);
  localparam int LINK_W   = $clog2(HEAP_WORDS);
  localparam int ALIGN_LG = $clog2(ALIGN_BYTES);
  localparam logic [31:0] CAP = 32'(HEAP_WORDS * ALIGN_BYTES);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_LINK
  } state_t;

  state_t      state;
  logic [HA_W-1:0] clr_cnt;
  entry_t      cur;
  logic [HA_W-1:0] cls_q;
  logic [16:0] head_off;
  logic [16:0] bump_offset;
  logic [31:0] bytes_in_use;

  logic [17:0] heads_mem [HEADS];
  logic [17:0] heads_rd;
  logic [17:0] links_mem [HEAP_WORDS];
  logic [17:0] links_rd;

  logic [HA_W-1:0]   cls_idx;
  logic [HA_W-1:0]   heads_raddr;
  logic              hw_en;
  logic [HA_W-1:0]   hw_addr;
  logic [17:0]       hw_data;
  logic              lw_en;
  logic [LINK_W-1:0] l_addr;
  logic [31:0]       limit;
  logic [17:0]       bump_sum;
  logic [31:0]       head_word;
  logic [31:0]       free_word;
  logic [31:0]       pop_word;
  logic              free_bad;

  // Derive class index, limits and word indexes
  always_comb begin
    cls_idx     = HA_W'(32'(q_entry.cls_main) * CLASS_COUNT + 32'(q_entry.cls_rem));
    heads_raddr = (state == S_IDLE) ? cls_idx : cls_q;
    limit       = (32'(heap_bytes) < CAP) ? 32'(heap_bytes) : CAP;
    bump_sum    = {1'b0, bump_offset} + {1'b0, cur.granted};
    head_word   = 32'(heads_rd[16:0]) >> ALIGN_LG;
    free_word   = cur.offset >> ALIGN_LG;
    pop_word    = 32'(head_off) >> ALIGN_LG;
    free_bad    = (cur.offset[ALIGN_LG-1:0] != '0) || (cur.offset >= 32'(bump_offset));
  end

  // Select memory writes and link address
  always_comb begin
    hw_en   = 1'b0;
    hw_addr = cls_q;
    hw_data = 18'd0;
    lw_en   = 1'b0;
    l_addr  = (state == S_HEAD) ? LINK_W'(free_word) : LINK_W'(head_word);
    case (state)
      S_CLEAR: begin
        hw_en   = 1'b1;
        hw_addr = clr_cnt;
      end
      S_HEAD: begin
        if (!cur.bad_size && cur.op == OP_FREE && !free_bad
            && free_word < 32'(HEAP_WORDS)) begin
          hw_en   = 1'b1;
          hw_data = {1'b1, cur.offset[16:0]};
          lw_en   = 1'b1;
        end
        if (!(!cur.bad_size && cur.op == OP_FREE)) l_addr = LINK_W'(head_word);
      end
      S_LINK: begin
        hw_en   = 1'b1;
        hw_data = (pop_word < 32'(HEAP_WORDS)) ? links_rd : 18'd0;
      end
      default: ;
    endcase
  end

  // Class head memory
  always_ff @(posedge clk) begin
    if (hw_en) heads_mem[hw_addr] <= hw_data;
    heads_rd <= heads_mem[heads_raddr];
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (lw_en) links_mem[l_addr] <= heads_rd;
    links_rd <= links_mem[l_addr];
  end

  assign pop      = (state == S_IDLE) && q_valid;
  assign clearing = (state == S_CLEAR);

  // Sequence each transaction and drive the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      bump_offset  <= 17'd0;
      bytes_in_use <= 32'd0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + HA_W'(1);
          if (clr_cnt == HA_W'(HEADS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_entry;
            cls_q <= cls_idx;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          head_off             <= heads_rd[16:0];
          result.block_address <= 32'd0;
          result.granted_size  <= cur.granted;
          result.in_use_total  <= bytes_in_use;
          result.status        <= ST_OK;
          state                <= S_IDLE;
          if (cur.bad_size) begin
            result.status <= ST_BAD_SIZE;
            done          <= 1'b1;
          end else if (cur.op == OP_ALLOC) begin
            if (heads_rd[17]) begin
              state <= S_LINK;
            end else if (32'(bump_sum) > limit) begin
              result.status <= ST_EXHAUSTED;
              done          <= 1'b1;
            end else begin
              result.block_address <= heap_base + 32'(bump_offset);
              result.in_use_total  <= bytes_in_use + 32'(cur.granted);
              bytes_in_use         <= bytes_in_use + 32'(cur.granted);
              bump_offset          <= bump_sum[16:0];
              done                 <= 1'b1;
            end
          end else begin
            if (free_bad) begin
              result.status <= ST_BAD_FREE;
            end else begin
              result.in_use_total <= bytes_in_use - 32'(cur.granted);
              bytes_in_use        <= bytes_in_use - 32'(cur.granted);
            end
            done <= 1'b1;
          end
        end
        S_LINK: begin
          result.block_address <= heap_base + 32'(head_off);
          result.granted_size  <= cur.granted;
          result.in_use_total  <= bytes_in_use + 32'(cur.granted);
          result.status        <= ST_OK;
          bytes_in_use         <= bytes_in_use + 32'(cur.granted);
          done                 <= 1'b1;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/size_class_free_list_allocator_top.sv */
// Size-class heap allocator. After reset the block clears its class-head table,
// one entry a cycle, with busy high. A transaction is taken when start is high
// and busy is low; busy also rises when the two-entry queue between the
// classifier and the executor is full. Each transaction gives exactly one
// result, shown for one cycle with done high; it cannot be held off. The
// executor passes through its head state on a bad size, a free or a bump
// allocation, and through its head and then its link state on an allocation
// from a free list, where the class-head read and then the dependent link read
// are each one synchronous memory access. Write heap_base and heap_bytes only
// while the block is idle.
module size_class_free_list_allocator_top #(
  parameter int CLASS_COUNT = 32,
  parameter int HEAP_WORDS  = 16384,
  parameter int ALIGN_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  scfl_pkg::req_t request,
  output logic           done,
  output scfl_pkg::rsp_t result,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [31:0]    cfg_data
);
  import scfl_pkg::*;
  `include "size_class_free_list_allocator_top_defines.svh"

  logic [31:0] heap_base;
  logic [16:0] heap_bytes;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;
  logic        clearing;
  entry_t      f_entry;
  entry_t      q_entry;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= 32'd0;
      heap_bytes <= HEAP_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAP_BASE:  heap_base  <= cfg_data;
        REG_HEAP_BYTES: heap_bytes <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign busy = q_full | clearing;

  scfl_front #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .request  (request),
    .heap_base(heap_base),
    .push     (push),
    .entry    (f_entry)
  );

  scfl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(f_entry),
    .pop     (pop),
    .full    (q_full),
    .valid   (q_valid),
    .rd_entry(q_entry)
  );

  scfl_back #(
    .CLASS_COUNT(CLASS_COUNT),
    .HEAP_WORDS (HEAP_WORDS),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .heap_base (heap_base),
    .heap_bytes(heap_bytes),
    .clearing  (clearing),
    .done      (done),
    .result    (result)
  );

  // Failed transactions grant no address; bad sizes grant no bytes, all others some
  `SCFL_ASSERT_NOW(a_fail_no_addr, done && result.status != ST_OK, result.block_address == 32'd0, "failed transaction returned an address")
  `SCFL_ASSERT_NOW(a_bad_size_zero, done && result.status == ST_BAD_SIZE, result.granted_size == 17'd0, "bad size carried a granted size")
  `SCFL_ASSERT_NOW(a_good_size_grant, done && result.status != ST_BAD_SIZE, result.granted_size != 17'd0, "valid size granted zero bytes")
  // Accepted transactions never enter while the head table is cleared
  `SCFL_ASSERT_NEXT(a_clear_blocks, clearing, busy || !clearing, "transaction accepted during clearing pass")

endmodule

/* test/size_class_free_list_allocator_top_test.sv */
module size_class_free_list_allocator_top_test;
  import scfl_pkg::*;

  localparam int CLASS_COUNT = 32;
  localparam int HEAP_WORDS  = 16384;
  localparam int WORD_BYTES  = 4;
  localparam int SIZE_CAP    = 65536;
  localparam int SPLIT_BITS  = 8;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic [31:0] offset;
    logic [16:0] size;
  } block_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        request = '0;
  logic        done;
  rsp_t        result;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_HEAP_BASE;
  logic [31:0] cfg_data = '0;

  size_class_free_list_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the allocator state and registers
  logic [31:0] heap_base_q  = '0;
  logic [16:0] heap_bytes_q = HEAP_BYTES_RESET;
  logic [17:0] list_heads [CLASS_COUNT*CLASS_COUNT] = '{default: '0};
  logic [17:0] list_links [HEAP_WORDS];
  logic [31:0] bump_q   = '0;
  logic [31:0] in_use_q = '0;

  req_t   requests_waiting[$];
  rsp_t   grants_due[$];
  block_t held_blocks[$];
  int     gap_pct = 0;
  int     issued = 0;
  int     errors = 0;

  always #1 clk = ~clk;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int bit_len(input int v);
    return $clog2(v + 1);
  endfunction

  // Round to a word multiple, then up to a power of two
  function automatic int pow2_up(input int s);
    int r;
    r = (s + WORD_BYTES - 1) & ~(WORD_BYTES - 1);
    return 1 << bit_len(r - 1);
  endfunction

  // Block size for a request, and its (main, remainder) class
  function automatic int block_size(input int s, output int cls);
    int p, bits, top, rest;
    p = pow2_up(s);
    bits = bit_len(s - 1);
    if (p > s && bits > SPLIT_BITS) begin
      top = 1 << (bits - 1);
      rest = pow2_up(s - top);
      if (top != rest) begin
        cls = (bits - 1) * CLASS_COUNT + bit_len(rest - 1);
        return top + rest;
      end
    end
    cls = bits * CLASS_COUNT;
    return p;
  endfunction

  // Apply one transaction to the mirror and return the grant it should give
  function automatic rsp_t grant_for(input req_t rq);
    rsp_t        rs;
    int          size, grant, cls, w;
    logic [31:0] off, limit;
    rs = '0;
    size = rq.request_size;
    if (size == 0 || size > SIZE_CAP) begin
      rs.status = ST_BAD_SIZE;
    end else begin
      grant = block_size(size, cls);
      rs.granted_size = grant[16:0];
      limit = (heap_bytes_q < HEAP_WORDS * WORD_BYTES) ? 32'(heap_bytes_q)
                                                       : HEAP_WORDS * WORD_BYTES;
      if (rq.op == OP_ALLOC) begin
        if (list_heads[cls][17]) begin
          off = list_heads[cls][16:0];
          w = int'(off >> 2);
          list_heads[cls] = (w < HEAP_WORDS) ? list_links[w] : '0;
          rs.block_address = heap_base_q + off;
          in_use_q += grant;
          held_blocks.push_back('{offset: off, size: rq.request_size});
        end else if (bump_q + grant > limit) begin
          rs.status = ST_EXHAUSTED;
        end else begin
          rs.block_address = heap_base_q + bump_q;
          held_blocks.push_back('{offset: bump_q, size: rq.request_size});
          bump_q += grant;
          in_use_q += grant;
        end
      end else begin
        off = rq.free_address - heap_base_q;
        if (off[1:0] != 2'b00 || off >= bump_q) begin
          rs.status = ST_BAD_FREE;
        end else begin
          w = int'(off >> 2);
          if (w < HEAP_WORDS) begin
            list_links[w] = list_heads[cls];
            list_heads[cls] = {1'b1, off[16:0]};
          end
          in_use_q -= grant;
        end
      end
    end
    rs.in_use_total = in_use_q;
    return rs;
  endfunction

  // Driver: hold start until taken, then present the next transaction or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) grants_due.push_back(grant_for(requests_waiting.pop_front()));
      if (requests_waiting.size() > 0 && $urandom_range(99) >= gap_pct) begin
        start <= 1'b1;
        request <= requests_waiting[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < PRINT_CAP) $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Monitor: check each result against the oldest outstanding grant
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst && done) begin
      if (grants_due.size() == 0) begin
        flag("result with nothing outstanding", result.block_address, '0);
      end else begin
        want = grants_due.pop_front();
        if (result.block_address !== want.block_address)
          flag("block_address", result.block_address, want.block_address);
        if (result.granted_size !== want.granted_size)
          flag("granted_size", 32'(result.granted_size), 32'(want.granted_size));
        if (result.in_use_total !== want.in_use_total)
          flag("in_use_total", result.in_use_total, want.in_use_total);
        if (result.status !== want.status)
          flag("status", 32'(result.status), 32'(want.status));
      end
    end
  end

  task automatic queue_item(input logic op, input int size, input logic [31:0] addr);
    req_t rq;
    while (requests_waiting.size() >= 3) @(negedge clk);
    rq.op = op;
    rq.request_size = size[16:0];
    rq.free_address = addr;
    requests_waiting.push_back(rq);
    issued++;
    gap_pct = (issued < 540) ? 38 : (issued < 1080) ? 59 : 0;
  endtask

  // Wait until every transaction has been answered and the block is idle
  task automatic drain();
    while (requests_waiting.size() > 0 || grants_due.size() > 0 || busy) @(negedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] value);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) heap_base_q = value;
    else heap_bytes_q = value[16:0];
    @(negedge clk);
  endtask

  // Mostly small sizes, a thin tail up to the largest
  function automatic int draw_size();
    int r;
    r = $urandom_range(999);
    if (r < 550) return $urandom_range(1, 64);
    if (r < 850) return $urandom_range(65, 512);
    if (r < 980) return $urandom_range(513, 4096);
    if (r < 996) return $urandom_range(4097, 16384);
    return $urandom_range(16385, SIZE_CAP);
  endfunction

  task automatic random_item();
    int          r, k;
    block_t      b;
    logic [31:0] below;
    r = $urandom_range(99);
    below = (bump_q >> 2) > 0 ? $urandom_range((bump_q >> 2) - 1) : 0;
    if (r < 7) begin
      // noise: any field value at all
      queue_item(1'($urandom_range(1)), $urandom_range(131071), $urandom);
    end else if (r < 12) begin
      // broken frees: misaligned, past the bump pointer, wrong size, double
      case ($urandom_range(3))
        0: queue_item(OP_FREE, draw_size(),
                      heap_base_q + (below << 2) + $urandom_range(1, 3));
        1: queue_item(OP_FREE, draw_size(),
                      heap_base_q + bump_q + ($urandom_range(255) << 2));
        2: begin
          if (held_blocks.size() > 0) begin
            k = $urandom_range(held_blocks.size() - 1);
            b = held_blocks[k];
            held_blocks.delete(k);
            queue_item(OP_FREE, draw_size(), heap_base_q + b.offset);
          end else begin
            queue_item(OP_ALLOC, draw_size(), $urandom);
          end
        end
        default: queue_item(OP_FREE, draw_size(), heap_base_q + (below << 2));
      endcase
    end else if (held_blocks.size() > 0 && $urandom_range(99) < 45) begin
      // return a live block with the size it was taken with
      k = $urandom_range(held_blocks.size() - 1);
      b = held_blocks[k];
      held_blocks.delete(k);
      queue_item(OP_FREE, b.size, heap_base_q + b.offset);
    end else begin
      queue_item(OP_ALLOC, draw_size(), $urandom);
    end
  endtask

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);

    // Directed: bad sizes, small classes, split classes, exhaustion, bad frees, reuse
    queue_item(OP_ALLOC, 0, '0);
    queue_item(OP_ALLOC, 131071, 32'hFFFFFFFF);
    queue_item(OP_FREE, 65537, '0);
    queue_item(OP_ALLOC, 1, '0);
    queue_item(OP_ALLOC, 2, '0);
    queue_item(OP_ALLOC, 3, '0);
    queue_item(OP_ALLOC, 4, '0);
    queue_item(OP_ALLOC, 5, '0);
    queue_item(OP_ALLOC, 257, '0);
    queue_item(OP_ALLOC, 320, '0);
    queue_item(OP_ALLOC, 400, '0);
    queue_item(OP_ALLOC, 512, '0);
    queue_item(OP_ALLOC, SIZE_CAP, '0);
    queue_item(OP_FREE, 1, 32'h0000_0002);
    queue_item(OP_FREE, 4, 32'hFFFF_FFFF);
    queue_item(OP_FREE, 4, 32'h0000_FFFC);
    queue_item(OP_FREE, 1, 32'h0000_0000);
    queue_item(OP_FREE, 3, 32'h0000_0008);
    queue_item(OP_FREE, 4, 32'h0000_000C);
    queue_item(OP_ALLOC, 4, '0);
    queue_item(OP_ALLOC, 3, '0);
    queue_item(OP_ALLOC, 1, '0);
    queue_item(OP_ALLOC, 1, '0);
    queue_item(OP_FREE, 2, 32'h0000_0004);
    queue_item(OP_ALLOC, 2, '0);

    repeat (400) random_item();

    // Highest base, smallest heap: only free-list reuse can succeed
    set_reg(REG_HEAP_BASE, 32'hFFFF_FFFC);
    set_reg(REG_HEAP_BYTES, 32'd4);
    repeat (250) random_item();

    // Random base, full heap; pause once until every grant is back
    set_reg(REG_HEAP_BASE, $urandom & 32'hFFFF_FFFC);
    set_reg(REG_HEAP_BYTES, SIZE_CAP);
    repeat (275) random_item();
    drain();
    repeat (275) random_item();

    // Zero base, random heap size
    set_reg(REG_HEAP_BASE, 32'h0000_0000);
    set_reg(REG_HEAP_BYTES, $urandom_range(4, SIZE_CAP));
    repeat (400) random_item();

    drain();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("[size_class_free_list_allocator_top] OK");
    end else begin
      $display("[size_class_free_list_allocator_top] ERROR");
    end
    $finish;
  end

  // Give up on a hang
  initial begin
    #400000;
    $display("[size_class_free_list_allocator_top] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/scfl_pkg.sv
rtl/scfl_front.sv
rtl/scfl_queue.sv
rtl/scfl_back.sv
rtl/size_class_free_list_allocator_top.sv
test/size_class_free_list_allocator_top_test.sv
